// ===== design/fupa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the fixed unit pool allocator.
// Has no dependencies; the top level, fupa_arith and fupa_checker import it.
package fupa_pkg;

    localparam int ADDR_W         = 32;
    localparam int UNIT_W         = 17;
    localparam int DATA_W         = 32;
    localparam int PADDR_W        = 3;
    localparam int STATUS_W       = 3;
    localparam int POOL_UNITS_DEF = 64;
    localparam int DIV_STEPS      = 32;
    localparam int STEP_W         = $clog2(DIV_STEPS + 1);

    localparam logic [UNIT_W-1:0] UNIT_BYTES_RST = UNIT_W'(64);

    // Request codes carried on req_type.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Register word indexes on the configuration port.
    localparam logic REG_POOL_BASE  = 1'b0;
    localparam logic REG_UNIT_BYTES = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RETURNED = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MUL = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } arith_sts_t;

endpackage

// ===== design/fixed_unit_pool_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the fixed unit pool allocator: sequencer, counters, register port.
// Depends on fupa_pkg, fupa_ram and fupa_arith.
//
// The block hands out and takes back equal-sized units of a memory pool that
// starts at pool_base and has units of unit_bytes bytes (zero counts as one).
// Request words enter on the in_valid/in_stall channel: req_type selects an
// allocate or a free of release_address. Every request produces exactly one
// result word on the out_valid/out_stall channel with the unit address, a
// status code and the free and allocated unit counts after the request.
//
// Requests are handled one at a time by a small sequencer around one shared
// bit-serial divide/multiply unit. A free divides the address offset by the
// unit size one quotient bit per cycle; an address outside the pool or off a
// unit boundary is answered as soon as the divide finishes, and any other
// address has its in-use mark checked first. An allocate reads the oldest
// free index from the free list and multiplies it by the unit size one index
// bit per cycle; on an empty pool it answers without any arithmetic.
// in_stall is low whenever the sequencer is idle,
// and a new word is accepted the cycle after the previous result is staged.
// The output register holds a finished result while the receiver stalls, and
// the next request is still accepted meanwhile; it then waits for the slot.
// After reset a clearing pass over all POOL_UNITS entries loads the free
// list with the indexes in order and clears every in-use mark; in_stall
// stays high during the pass, while register writes are taken as usual.
module fixed_unit_pool_allocator #(
    parameter int POOL_UNITS = fupa_pkg::POOL_UNITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [fupa_pkg::ADDR_W-1:0]         release_address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fupa_pkg::ADDR_W-1:0]         unit_address,
    output logic [fupa_pkg::STATUS_W-1:0]       status,
    output logic [$clog2(POOL_UNITS + 1)-1:0]   free_units,
    output logic [$clog2(POOL_UNITS + 1)-1:0]   used_units,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fupa_pkg::PADDR_W-1:0]        paddr,
    input  logic [fupa_pkg::DATA_W-1:0]         pwdata,
    output logic [fupa_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import fupa_pkg::*;

    localparam int IDX_W = $clog2(POOL_UNITS);
    localparam int CNT_W = $clog2(POOL_UNITS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(POOL_UNITS - 1);
    localparam logic [CNT_W-1:0]  UNITS_CNT  = CNT_W'(POOL_UNITS);
    localparam logic [ADDR_W-1:0] LAST_QUOT  = ADDR_W'(POOL_UNITS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_MUL,
        S_DIV,
        S_USE_CHK,
        S_DONE
    } state_t;

    // Configuration registers. Writes must only arrive while the sequencer is idle; the block does not enforce this.
    logic [ADDR_W-1:0] pool_base_reg;
    logic [UNIT_W-1:0] unit_bytes_reg;
    logic [UNIT_W-1:0] eff_unit;
    logic              cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign eff_unit  = (unit_bytes_reg == '0) ? UNIT_W'(1) : unit_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            unit_bytes_reg <= UNIT_BYTES_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_POOL_BASE:  pool_base_reg  <= pwdata;
                REG_UNIT_BYTES: unit_bytes_reg <= pwdata[UNIT_W-1:0];
                default:        pool_base_reg  <= pool_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_POOL_BASE:  prdata = pool_base_reg;
            REG_UNIT_BYTES: prdata = DATA_W'(unit_bytes_reg);
            default:        prdata = '0;
        endcase
    end

    // Sequencer state, free-list pointers and the output register.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    status_t           out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_free_reg, out_free_next;
    logic [CNT_W-1:0]  out_used_reg, out_used_next;

    // Free list memory and in-use mark memory.
    logic              fifo_we;
    logic [IDX_W-1:0]  fifo_waddr, fifo_wdata, fifo_rdata;
    logic              use_we;
    logic [IDX_W-1:0]  use_waddr, use_raddr;
    logic              use_wdata, use_rdata;

    // Shared arithmetic unit.
    arith_ctl_t        actl;
    arith_sts_t        asts;
    logic [ADDR_W-1:0] a_opa, a_result;
    logic [ADDR_W-1:0] offset;
    logic              in_pool;

    assign offset = release_address - pool_base_reg;

    // offset <= (POOL_UNITS-1)*unit exactly when the quotient is below the
    // last index, or equals it with nothing left over.
    assign in_pool = (a_result < LAST_QUOT) || ((a_result == LAST_QUOT) && asts.rem_zero);

    // While dividing, the quotient register addresses the in-use memory so the
    // mark is ready the cycle after the divide finishes.
    assign use_raddr = (state_reg == S_DIV) ? a_result[IDX_W-1:0] : idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        idx_next        = idx_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        out_used_next   = out_used_reg;
        out_valid_next  = out_valid_reg && out_stall;
        fifo_we         = 1'b0;
        fifo_waddr      = tail_reg;
        fifo_wdata      = idx_reg;
        use_we          = 1'b0;
        use_waddr       = idx_reg;
        use_wdata       = 1'b0;
        actl.start      = 1'b0;
        actl.op         = OP_DIV;
        a_opa           = offset;

        case (state_reg)
            S_CLEAR:
            begin
                fifo_we    = 1'b1;
                fifo_waddr = clr_reg;
                fifo_wdata = clr_reg;
                use_we     = 1'b1;
                use_waddr  = clr_reg;
                use_wdata  = 1'b0;
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_FREE)
                    begin
                        actl.start = 1'b1;
                        actl.op    = OP_DIV;
                        state_next = S_DIV;
                    end
                    else if (free_reg == '0)
                    begin
                        res_addr_next   = '0;
                        res_status_next = ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ALLOC_RD;
                    end
                end
            end
            S_ALLOC_RD:
            begin
                // The oldest free index is now on the free list read port.
                idx_next   = fifo_rdata;
                actl.start = 1'b1;
                actl.op    = OP_MUL;
                a_opa      = ADDR_W'(fifo_rdata);
                use_we     = 1'b1;
                use_waddr  = fifo_rdata;
                use_wdata  = 1'b1;
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                free_next  = free_reg - CNT_W'(1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (asts.done)
                begin
                    res_addr_next   = pool_base_reg + a_result;
                    res_status_next = ST_GRANTED;
                    state_next      = S_DONE;
                end
            end
            S_DIV:
            begin
                if (asts.done)
                begin
                    idx_next      = a_result[IDX_W-1:0];
                    res_addr_next = '0;
                    if (!in_pool)
                    begin
                        res_status_next = ST_OUTSIDE;
                        state_next      = S_DONE;
                    end
                    else if (!asts.rem_zero)
                    begin
                        res_status_next = ST_IGNORED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_USE_CHK;
                    end
                end
            end
            S_USE_CHK:
            begin
                if (use_rdata && (free_reg < UNITS_CNT))
                begin
                    use_we          = 1'b1;
                    use_waddr       = idx_reg;
                    use_wdata       = 1'b0;
                    fifo_we         = 1'b1;
                    fifo_waddr      = tail_reg;
                    fifo_wdata      = idx_reg;
                    tail_next       = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                    free_next       = free_reg + CNT_W'(1);
                    res_status_next = ST_RETURNED;
                end
                else
                begin
                    res_status_next = ST_IGNORED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    out_free_next   = free_reg;
                    out_used_next   = UNITS_CNT - free_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_reg       <= UNITS_CNT;
            idx_reg        <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= ST_GRANTED;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= ST_GRANTED;
            out_free_reg   <= '0;
            out_used_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_reg       <= free_next;
            idx_reg        <= idx_next;
            res_addr_reg   <= res_addr_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_addr_reg   <= out_addr_next;
            out_status_reg <= out_status_next;
            out_free_reg   <= out_free_next;
            out_used_reg   <= out_used_next;
        end
    end

    fupa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_UNITS)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    fupa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_UNITS)
    ) u_use_ram (
        .clk   (clk),
        .we    (use_we),
        .waddr (use_waddr),
        .wdata (use_wdata),
        .raddr (use_raddr),
        .rdata (use_rdata)
    );

    fupa_arith #(
        .IDX_W (IDX_W)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (actl),
        .opa    (a_opa),
        .opb    (eff_unit),
        .sts    (asts),
        .result (a_result)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign unit_address = out_addr_reg;
    assign status       = out_status_reg;
    assign free_units   = out_free_reg;
    assign used_units   = out_used_reg;

endmodule

// ===== design/fupa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fupa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fupa_arith.sv =====
`timescale 1ns / 1ps
// Shared bit-serial arithmetic unit: restoring divide (32 steps) and
// shift-add multiply (one step per index bit). Depends on fupa_pkg.
module fupa_arith #(
    parameter int IDX_W = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fupa_pkg::arith_ctl_t        ctl,
    input  logic [fupa_pkg::ADDR_W-1:0] opa,
    input  logic [fupa_pkg::UNIT_W-1:0] opb,
    output fupa_pkg::arith_sts_t        sts,
    output logic [fupa_pkg::ADDR_W-1:0] result
);
    import fupa_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    arith_op_t         op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] acc_reg, acc_next;
    logic [UNIT_W-1:0] rem_reg, rem_next;
    logic [UNIT_W-1:0] b_reg, b_next;

    logic [UNIT_W:0]   shifted;
    logic [UNIT_W+1:0] diff;
    logic              last_step;

    assign shifted   = {rem_reg, acc_reg[ADDR_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, b_reg};
    assign last_step = (op_reg == OP_DIV) ? (step_reg == STEP_W'(DIV_STEPS - 1))
                                          : (step_reg == STEP_W'(IDX_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            step_next = '0;
            b_next    = opb;
            if (ctl.op == OP_DIV)
            begin
                acc_next = opa;
                rem_next = '0;
            end
            else
            begin
                acc_next = '0;
                rem_next = {opa[IDX_W-1:0], {(UNIT_W - IDX_W){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                // A clear borrow bit means the divisor fits: quotient bit is one.
                if (!diff[UNIT_W+1])
                begin
                    rem_next = diff[UNIT_W-1:0];
                    acc_next = {acc_reg[ADDR_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[UNIT_W-1:0];
                    acc_next = {acc_reg[ADDR_W-2:0], 1'b0};
                end
            end
            else
            begin
                acc_next = {acc_reg[ADDR_W-2:0], 1'b0}
                         + (rem_reg[UNIT_W-1] ? ADDR_W'(b_reg) : '0);
                rem_next = {rem_reg[UNIT_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            step_reg <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            b_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            step_reg <= step_next;
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            b_reg    <= b_next;
        end
    end

    assign sts.done     = done_reg;
    assign sts.rem_zero = (rem_reg == '0);
    assign result       = acc_reg;

endmodule

// ===== design/fupa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the fixed unit pool allocator, bound to the top level.
// Depends on fupa_pkg and fixed_unit_pool_allocator.
module fupa_checker #(
    parameter int POOL_UNITS = fupa_pkg::POOL_UNITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [fupa_pkg::ADDR_W-1:0]       unit_address,
    input logic [fupa_pkg::STATUS_W-1:0]     status,
    input logic [$clog2(POOL_UNITS + 1)-1:0] free_units,
    input logic [$clog2(POOL_UNITS + 1)-1:0] used_units
);
    import fupa_pkg::*;

    localparam int CNT_W = $clog2(POOL_UNITS + 1);

    // A word that is stalled stays on the output with its address and status unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(unit_address) && $stable(status))
        else $error("stalled result word changed");

    // Only a grant carries a nonzero address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_GRANTED) |-> (unit_address == '0))
        else $error("nonzero address on a result that is not a grant");

    // Free and allocated counts always add up to the pool size.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((CNT_W + 1)'(free_units) + (CNT_W + 1)'(used_units)
                       == (CNT_W + 1)'(POOL_UNITS)))
        else $error("free and used counts do not add up to the pool size");

    // An empty pool is reported only when no unit is free.
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (free_units == '0))
        else $error("pool reported empty while units are free");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted back to back");

endmodule

bind fixed_unit_pool_allocator fupa_checker #(
    .POOL_UNITS (POOL_UNITS)
) u_fupa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .unit_address (unit_address),
    .status       (status),
    .free_units   (free_units),
    .used_units   (used_units)
);
